### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition against another in the same cycle.
`define WTD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check a condition against another in the next cycle.
`define WTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/wtd_pkg.sv
// Types and constants for the window threshold debouncer.
`default_nettype none

package wtd_pkg;

  localparam int unsigned THRESH_W  = 4;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned HCOUNT_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 2'd2;

  localparam logic [THRESH_W-1:0]  THRESHOLD_RST = 4'd5;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd50;

  typedef struct packed {
    logic              sample;
    logic              saturate;
    logic [TIME_W-1:0] time_ms;
  } item_t;

  typedef struct packed {
    logic [THRESH_W-1:0]  threshold_count;
    logic [TIMEOUT_W-1:0] stale_timeout_ms;
    logic                 invert_output;
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/wtd_if.sv
// Handshake channel interfaces for samples, results and register writes.
`default_nettype none

interface wtd_sample_if;
  logic                      valid;
  logic                      ready;
  logic                      sample;
  logic                      saturate;
  logic [wtd_pkg::TIME_W-1:0] time_ms;

  modport source (output valid, sample, saturate, time_ms, input ready);
  modport sink   (input valid, sample, saturate, time_ms, output ready);
endinterface

interface wtd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        level;
  logic [wtd_pkg::HCOUNT_W-1:0] high_count;

  modport source (output valid, level, high_count, input ready);
  modport sink   (input valid, level, high_count, output ready);
endinterface

interface wtd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wtd_pkg::CFG_IDX_W-1:0] index;
  logic [wtd_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/wtd_window.sv
// Sample window, write pointer and last-read time, with the high-sample count.
`default_nettype none

module wtd_window #(
  parameter int unsigned WINDOW = 8,
  parameter int unsigned CNT_W  = 4
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               advance,
  input  wire wtd_pkg::item_t               item,
  input  wire [wtd_pkg::TIMEOUT_W-1:0]      stale_timeout_ms,
  output logic [CNT_W-1:0]                  count
);
  import wtd_pkg::*;

  localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [WINDOW-1:0] window;
  logic [WINDOW-1:0] window_next;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  ptr_next;
  logic [TIME_W-1:0] last_time;
  logic [TIME_W-1:0] elapsed;
  logic              stale;

  assign elapsed = item.time_ms - last_time;
  assign stale   = elapsed > {{(TIME_W-TIMEOUT_W){1'b0}}, stale_timeout_ms};

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      if (ptr == PTR_W'(i) || item.saturate) begin
        window_next[i] = item.sample;
      end else if (stale) begin
        window_next[i] = 1'b0;
      end else begin
        window_next[i] = window[i];
      end
    end
  end

  assign ptr_next = (ptr == PTR_W'(WINDOW-1)) ? '0 : ptr + PTR_W'(1);
  assign count    = CNT_W'($countones(window_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      ptr       <= '0;
      last_time <= '0;
    end else if (advance) begin
      window    <= window_next;
      ptr       <= ptr_next;
      last_time <= item.time_ms;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/window_threshold_debouncer_top.sv
// Top level of the sliding-window threshold debouncer.
// Usage:
//   samples : one word per raw pin sample with its saturate flag and the
//             current millisecond time.
//   results : one word per sample: debounced level and the count of high
//             samples in the window after the write.
//   cfg     : register writes (index 0 threshold, 1 stale timeout, 2 invert);
//             always ready, write only while no sample is in flight.
// Datapath: a taken sample is registered in the input register; the window
//   update and the population count of WINDOW bits sit between it and the
//   result register. Throughput: one sample per cycle while no result is
//   held back by a low results.ready.
// Reset: window cleared, pointer and last-read time zero, registers back
//   to threshold 5, timeout 50 ms, no inversion; both stages emptied.
// Stall: a held result keeps its word; one more sample waits in the input
//   register, then samples.ready drops until results.ready returns.
`default_nettype none

`include "assert_macros.svh"

module window_threshold_debouncer_top #(
  parameter int unsigned WINDOW = 8
) (
  input  wire          clk,
  input  wire          rst,
  wtd_sample_if.sink   samples,
  wtd_result_if.source results,
  wtd_cfg_if.sink      cfg
);
  import wtd_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned CMP_W = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;

  cfg_t             cfg_regs;
  item_t            item;
  logic             item_valid;
  logic             advance;
  logic [CNT_W-1:0] count;
  logic [CMP_W-1:0] count_ext;
  logic             res_valid;
  logic             res_level;
  logic [CMP_W-1:0] res_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.threshold_count  <= THRESHOLD_RST;
      cfg_regs.stale_timeout_ms <= TIMEOUT_RST;
      cfg_regs.invert_output    <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_THRESHOLD: cfg_regs.threshold_count  <= cfg.data[THRESH_W-1:0];
        REG_TIMEOUT:   cfg_regs.stale_timeout_ms <= cfg.data[TIMEOUT_W-1:0];
        REG_INVERT:    cfg_regs.invert_output    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign advance       = item_valid && (!res_valid || results.ready);
  assign samples.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (samples.ready) begin
      item_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      item.sample   <= samples.sample;
      item.saturate <= samples.saturate;
      item.time_ms  <= samples.time_ms;
    end
  end

  wtd_window #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W)
  ) u_window (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .item             (item),
    .stale_timeout_ms (cfg_regs.stale_timeout_ms),
    .count            (count)
  );

  assign count_ext = CMP_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_count <= count_ext;
      res_level <= (count_ext >= CMP_W'(cfg_regs.threshold_count))
                   ^ cfg_regs.invert_output;
    end
  end

  assign results.valid      = res_valid;
  assign results.level      = res_level;
  assign results.high_count = res_count[HCOUNT_W-1:0];

  `WTD_ASSERT_NEXT(a_take_fills_stage, !rst && samples.valid && samples.ready, item_valid)
  `WTD_ASSERT_NEXT(a_advance_gives_result, !rst && advance, res_valid)
  `WTD_ASSERT_NEXT(a_drain_empties, !rst && res_valid && results.ready && !advance, !res_valid)
  `WTD_ASSERT_NOW(a_free_stage_ready, item_valid && !res_valid, samples.ready)

endmodule

`default_nettype wire

### dv/tb_window_threshold_debouncer_top.sv
// Testbench for the window threshold debouncer: directed and random samples.
`timescale 1ns / 1ps

module tb_window_threshold_debouncer_top;
  import wtd_pkg::*;

  localparam int unsigned WIN         = 8;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 155;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                level;
    logic [HCOUNT_W-1:0] high_count;
  } level_word_t;

  bit   clk = 1'b0;
  logic rst = 1'b1;

  wtd_sample_if smp_if ();
  wtd_result_if res_if ();
  wtd_cfg_if    cfg_if ();

  window_threshold_debouncer_top #(.WINDOW(WIN)) DUT (
    .clk    (clk),
    .rst    (rst),
    .samples(smp_if),
    .results(res_if),
    .cfg    (cfg_if)
  );

  logic [WIN-1:0]       win_bits = '0;
  int unsigned          wr_ptr   = 0;
  logic [TIME_W-1:0]    last_ms  = '0;
  logic [THRESH_W-1:0]  thr_cnt  = THRESHOLD_RST;
  logic [TIMEOUT_W-1:0] stale_ms = TIMEOUT_RST;
  logic                 inv_out  = 1'b0;

  level_word_t       expected_words[$];
  int unsigned       err_cnt      = 0;
  int unsigned       cyc_cnt      = 0;
  bit                src_burst    = 1'b0;
  bit                snk_burst    = 1'b0;
  bit                hold_req     = 1'b0;
  bit                smp_offering = 1'b0;
  logic [TIME_W-1:0] now_ms       = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic level_word_t debounce_predict(input item_t it);
    logic [TIME_W-1:0] elapsed;
    int unsigned       ones;
    level_word_t       w;
    elapsed = it.time_ms - last_ms;
    if (it.saturate) begin
      win_bits = {WIN{it.sample}};
    end else if (elapsed > TIME_W'(stale_ms)) begin
      win_bits = '0;
    end
    last_ms = it.time_ms;
    win_bits[wr_ptr] = it.sample;
    wr_ptr = (wr_ptr + 1 >= WIN) ? 0 : wr_ptr + 1;
    ones = $countones(win_bits);
    w.level = (ones >= thr_cnt) ^ inv_out;
    w.high_count = HCOUNT_W'(ones);
    return w;
  endfunction

  task automatic drop_sample_valid();
    if (smp_offering) begin
      smp_if.valid <= 1'b0;
      smp_offering = 1'b0;
    end
  endtask

  task automatic wait_results_drained();
    drop_sample_valid();
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic send_sample(input logic smp, input logic sat, input logic [TIME_W-1:0] t);
    int unsigned gap;
    item_t       it;
    gap = src_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      drop_sample_valid();
      repeat (gap) @(posedge clk);
    end
    it.sample   = smp;
    it.saturate = sat;
    it.time_ms  = t;
    smp_if.valid    <= 1'b1;
    smp_if.sample   <= smp;
    smp_if.saturate <= sat;
    smp_if.time_ms  <= t;
    smp_offering = 1'b1;
    do @(posedge clk); while (!smp_if.ready);
    expected_words.push_back(debounce_predict(it));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    wait_results_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_cnt  = val[THRESH_W-1:0];
      REG_TIMEOUT:   stale_ms = val[TIMEOUT_W-1:0];
      REG_INVERT:    inv_out  = val[0];
      default: ;
    endcase
  endtask

  task automatic test_default_window();
    for (int k = 1; k <= 5; k++) send_sample(1'b1, 1'b0, 32'(10 * k));
    // elapsed equal to timeout keeps the window, one more clears it
    send_sample(1'b1, 1'b0, 32'd100);
    send_sample(1'b1, 1'b0, 32'd151);
    send_sample(1'b0, 1'b0, 32'd140);
  endtask

  task automatic test_threshold_extremes();
    write_reg(REG_THRESHOLD, 16'hFFF0);
    send_sample(1'b0, 1'b1, 32'd200);
    write_reg(REG_THRESHOLD, 16'hFFF8);
    send_sample(1'b1, 1'b1, 32'd201);
    send_sample(1'b0, 1'b0, 32'd202);
    write_reg(REG_THRESHOLD, 16'd15);
    send_sample(1'b1, 1'b1, 32'd203);
    write_reg(REG_THRESHOLD, 16'd9);
    send_sample(1'b1, 1'b1, 32'd203);
  endtask

  task automatic test_timeout_extremes();
    write_reg(REG_TIMEOUT, 16'd0);
    send_sample(1'b1, 1'b0, 32'd204);
    send_sample(1'b1, 1'b0, 32'd204);
    send_sample(1'b1, 1'b0, 32'd205);
    write_reg(REG_TIMEOUT, 16'hFFFF);
    send_sample(1'b1, 1'b0, 32'hFFFF_0000);
    send_sample(1'b1, 1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 1'b0, 32'h0000_FFFE);
    send_sample(1'b1, 1'b0, 32'h0001_FFFF);
  endtask

  task automatic test_invert_and_unused_reg();
    write_reg(REG_INVERT, 16'hFFFF);
    send_sample(1'b1, 1'b1, 32'h0002_0000);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_sample(1'b0, 1'b0, 32'h0002_0001);
    write_reg(REG_INVERT, 16'd0);
  endtask

  task automatic test_backpressure();
    src_burst = 1'b1;
    hold_req  = 1'b1;
    repeat (32) begin
      now_ms = now_ms + $urandom_range(0, 10);
      send_sample(1'($urandom_range(0, 1)), 1'b0, now_ms);
    end
    wait_results_drained();
    src_burst = 1'b0;
  endtask

  task automatic test_random_debounce();
    logic [THRESH_W-1:0]  thr;
    logic [TIMEOUT_W-1:0] tmo;
    logic                 btn;
    now_ms = $urandom();
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin thr = 4'd0;  tmo = '0;    end
        1: begin thr = 4'd8;  tmo = '1;    end
        2: begin thr = 4'd15; tmo = 16'd1; end
        default: begin
          thr = THRESH_W'($urandom_range(1, 9));
          tmo = TIMEOUT_W'($urandom_range(2, 80));
        end
      endcase
      write_reg(REG_THRESHOLD, {12'($urandom()), thr});
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_INVERT, {15'($urandom()), 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, 16'($urandom()));
      src_burst = ($urandom_range(0, 3) == 0);
      snk_burst = ($urandom_range(0, 3) == 0);
      btn = 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 11) == 0) btn = ~btn;
        case ($urandom_range(0, 19))
          0: now_ms = $urandom();
          1: now_ms = now_ms - $urandom_range(1, 1000);
          2: now_ms = now_ms + stale_ms + 1;
          3: now_ms = now_ms + stale_ms;
          default: now_ms = now_ms + $urandom_range(0, (stale_ms < 40) ? stale_ms : 40);
        endcase
        send_sample(btn ^ ($urandom_range(0, 5) == 0), $urandom_range(0, 24) == 0, now_ms);
      end
    end
    src_burst = 1'b0;
    snk_burst = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned gap;
    res_if.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = snk_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  always @(posedge clk) begin : check_words
    level_word_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with no expectation: level %0d high_count %0d",
               res_if.level, res_if.high_count);
        err_cnt++;
      end else begin
        want = expected_words.pop_front();
        if (res_if.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, res_if.level);
          err_cnt++;
        end
        if (res_if.high_count !== want.high_count) begin
          $error("high_count: expected %0d, got %0d", want.high_count, res_if.high_count);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    smp_if.valid    <= 1'b0;
    smp_if.sample   <= 1'b0;
    smp_if.saturate <= 1'b0;
    smp_if.time_ms  <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_default_window();
    test_threshold_extremes();
    test_timeout_extremes();
    test_invert_and_unused_reg();
    test_backpressure();
    test_random_debounce();
    wait_results_drained();
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
